// ----- rtl/core/ptw4k_pkg.sv -----
package ptw4k_pkg;

  // Store geometry
  localparam int TablePages     = 16;
  localparam int EntriesPerPage = 512;
  localparam int StoreWords     = TablePages * EntriesPerPage;
  localparam int StoreAw        = $clog2(StoreWords);
  localparam int PageW          = (TablePages > 1) ? $clog2(TablePages) : 1;
  localparam int DescW          = 64;
  localparam int VaW            = 48;
  localparam int IdxW           = 9;

  // Descriptor bits
  localparam int DescValidBit = 0;
  localparam int DescTableBit = 1;

  // Item opcodes
  localparam logic OpWrite     = 1'b0;
  localparam logic OpTranslate = 1'b1;

  localparam logic [1:0] LevelFirst = 2'd0;
  localparam logic [1:0] LevelLast  = 2'd3;

  typedef enum logic [1:0] {
    WalkIdle,
    WalkRead,
    WalkDone
  } walk_state_e;

  typedef struct packed {
    logic             opcode;
    logic [12:0]      word_index;
    logic [DescW-1:0] write_data;
    logic [VaW-1:0]   virt_addr;
  } req_t;

  typedef struct packed {
    logic [VaW-1:0] phys_addr;
    logic           fault;
    logic [1:0]     leaf_level;
  } rsp_t;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [StoreAw-1:0] addr;
    logic [DescW-1:0]   wdata;
  } mem_req_t;

  // Table index taken from the virtual address at a given level
  function automatic logic [IdxW-1:0] va_index(input logic [VaW-1:0] va,
                                               input logic [1:0]     lvl);
    logic [IdxW-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  // Offset bits below the leaf boundary of a given level
  function automatic logic [VaW-1:0] offset_mask(input logic [1:0] lvl);
    logic [VaW-1:0] mask;
    case (lvl)
      2'd0:    mask = {9'd0, {39{1'b1}}};
      2'd1:    mask = {18'd0, {30{1'b1}}};
      2'd2:    mask = {27'd0, {21{1'b1}}};
      default: mask = {36'd0, {12{1'b1}}};
    endcase
    return mask;
  endfunction

  // Store word address of an entry within a page
  function automatic logic [StoreAw-1:0] store_addr(input logic [PageW-1:0] page,
                                                    input logic [IdxW-1:0]  idx);
    return StoreAw'({page, idx});
  endfunction

endpackage

// ----- rtl/core/ptw4k_req_if.sv -----
interface ptw4k_req_if;
  logic              valid;
  logic              ready;
  ptw4k_pkg::req_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/ptw4k_rsp_if.sv -----
interface ptw4k_rsp_if;
  logic              valid;
  logic              ready;
  ptw4k_pkg::rsp_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/ptw4k_ram.sv -----
module ptw4k_ram #(
  parameter int Width = 64,
  parameter int Depth = 8192,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write or read one word, read data registered
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/ptw4k_walker.sv -----
module ptw4k_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [3:0]                    root_page_i,
  input  logic [ptw4k_pkg::DescW-1:0]   mem_rdata_i,
  output ptw4k_pkg::mem_req_t           mem_req_o,
  ptw4k_req_if.sink                     req_i,
  ptw4k_rsp_if.source                   rsp_o
);

  ptw4k_pkg::walk_state_e         state_q, state_d;
  logic [1:0]                     lvl_q, lvl_d;
  logic [ptw4k_pkg::VaW-1:0]      va_q, va_d;
  ptw4k_pkg::rsp_t                res_q, res_d;
  ptw4k_pkg::rsp_t                out_q;
  logic                           out_valid_q;
  logic                           out_free;
  logic                           root_ok;
  logic                           wr_ok;
  logic                           desc_valid;
  logic                           desc_table;
  logic                           next_ok;
  logic [ptw4k_pkg::VaW-1:0]      lvl_mask;

  // Decode the item and the descriptor just read
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign root_ok    = 32'(root_page_i) < ptw4k_pkg::TablePages;
  assign wr_ok      = 32'(req_i.payload.word_index) < ptw4k_pkg::StoreWords;
  assign desc_valid = mem_rdata_i[ptw4k_pkg::DescValidBit];
  assign desc_table = mem_rdata_i[ptw4k_pkg::DescTableBit];
  assign next_ok    = mem_rdata_i[47:12] < 36'(ptw4k_pkg::TablePages);
  assign lvl_mask   = ptw4k_pkg::offset_mask(lvl_q);

  assign req_i.ready   = (state_q == ptw4k_pkg::WalkIdle);
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // Next state, store access and result
  always_comb begin
    state_d         = state_q;
    lvl_d           = lvl_q;
    va_d            = va_q;
    res_d           = res_q;
    mem_req_o       = '0;
    mem_req_o.wdata = req_i.payload.write_data;
    case (state_q)
      ptw4k_pkg::WalkIdle: begin
        if (req_i.valid) begin
          res_d   = '0;
          state_d = ptw4k_pkg::WalkDone;
          if (req_i.payload.opcode == ptw4k_pkg::OpWrite) begin
            mem_req_o.en   = wr_ok;
            mem_req_o.we   = wr_ok;
            mem_req_o.addr = ptw4k_pkg::StoreAw'(req_i.payload.word_index);
          end else begin
            va_d  = req_i.payload.virt_addr;
            lvl_d = ptw4k_pkg::LevelFirst;
            if (root_ok) begin
              mem_req_o.en   = 1'b1;
              mem_req_o.addr = ptw4k_pkg::store_addr(
                  ptw4k_pkg::PageW'(root_page_i),
                  ptw4k_pkg::va_index(req_i.payload.virt_addr, ptw4k_pkg::LevelFirst));
              state_d        = ptw4k_pkg::WalkRead;
            end else begin
              res_d.fault = 1'b1;
            end
          end
        end
      end
      ptw4k_pkg::WalkRead: begin
        if (!desc_valid || (lvl_q == ptw4k_pkg::LevelLast && !desc_table)) begin
          res_d.fault = 1'b1;
          state_d     = ptw4k_pkg::WalkDone;
        end else if (lvl_q == ptw4k_pkg::LevelLast || !desc_table) begin
          res_d.phys_addr  = (mem_rdata_i[47:0] & ~lvl_mask) | (va_q & lvl_mask);
          res_d.leaf_level = lvl_q;
          state_d          = ptw4k_pkg::WalkDone;
        end else if (!next_ok) begin
          res_d.fault = 1'b1;
          state_d     = ptw4k_pkg::WalkDone;
        end else begin
          // Descend one level
          mem_req_o.en   = 1'b1;
          mem_req_o.addr = ptw4k_pkg::store_addr(
              ptw4k_pkg::PageW'(mem_rdata_i[47:12]),
              ptw4k_pkg::va_index(va_q, lvl_q + 2'd1));
          lvl_d          = lvl_q + 2'd1;
        end
      end
      ptw4k_pkg::WalkDone: begin
        if (out_free) begin
          state_d = ptw4k_pkg::WalkIdle;
        end
      end
      default: begin
        state_d = ptw4k_pkg::WalkIdle;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptw4k_pkg::WalkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk context and pending result
  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    va_q  <= va_d;
    res_q <= res_d;
  end

  // Output register: load from the done state, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ptw4k_pkg::WalkDone && out_free) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ptw4k_pkg::WalkDone && out_free) begin
      out_q <= res_q;
    end
  end

  a_read_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
      state_q == ptw4k_pkg::WalkRead |-> $past(mem_req_o.en && !mem_req_o.we))
    else $error("descriptor evaluated without a store read the cycle before");

  a_level_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ptw4k_pkg::WalkRead && $past(state_q) == ptw4k_pkg::WalkRead)
      |-> lvl_q == $past(lvl_q) + 2'd1)
    else $error("walk level did not advance by one");

  a_fault_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (rsp_o.valid && rsp_o.payload.fault)
      |-> (rsp_o.payload.phys_addr == '0 && rsp_o.payload.leaf_level == 2'd0))
    else $error("fault result carries address or level");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(rsp_o.valid) |-> $past(state_q == ptw4k_pkg::WalkDone))
    else $error("result presented without a finished item");

endmodule

// ----- rtl/core/page_table_walker_4k_unit.sv -----
// Flow: a write item goes from the idle state to the done state; a translate item reads one
// descriptor per level in the read state, from the root page down, until a leaf or a fault.
// Items are taken only in the idle state, one at a time, each waiting on the dependent reads
// of the single port descriptor store; a held result stalls the input.
// Reset: control state and root_page clear at once; the store is undefined until
// written and gets no clearing pass.
module page_table_walker_4k_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  ptw4k_req_if.sink   req_i,
  ptw4k_rsp_if.source rsp_o
);

  logic [3:0]                    root_page_q;
  ptw4k_pkg::mem_req_t           mem_req;
  logic [ptw4k_pkg::DescW-1:0]   mem_rdata;

  // Root page register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_page_q <= 4'd0;
    end else if (cfg_we_i) begin
      root_page_q <= cfg_wdata_i;
    end
  end

  // Descriptor store
  ptw4k_ram #(
    .Width (ptw4k_pkg::DescW),
    .Depth (ptw4k_pkg::StoreWords)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  // Walk sequencer
  ptw4k_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .root_page_i (root_page_q),
    .mem_rdata_i (mem_rdata),
    .mem_req_o   (mem_req),
    .req_i       (req_i),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- test/ptw4k_walk_checker.sv -----
`timescale 1ns / 1ps
module ptw4k_walk_checker
  import ptw4k_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  ptw4k_req_if        req_mon,
  ptw4k_rsp_if        rsp_mon,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  // Shadow of the descriptor store and of the root page register
  logic [DescW-1:0] desc_shadow [StoreWords];
  logic [PageW-1:0] root_page_q;

  // Results owed by the block, oldest first
  rsp_t rsp_due [$];

  // Walk the shadow tables from the root page and form the translation result
  function automatic rsp_t predict_translation(input logic [VaW-1:0] va);
    rsp_t             res;
    logic [35:0]      page;
    logic [DescW-1:0] desc;
    logic [IdxW-1:0]  entry;
    logic [VaW-1:0]   low_bits;
    int               boundary;
    int               lvl;
    res       = '0;
    res.fault = 1'b1;
    page      = 36'(root_page_q);
    for (lvl = 0; lvl < 4; lvl++) begin
      boundary = 39 - 9 * lvl;
      entry    = IdxW'(va >> boundary);
      if (page >= TablePages) return res;
      desc = desc_shadow[int'(page) * EntriesPerPage + int'(entry)];
      // invalid entry, or a level 3 entry that is not a page
      if (!desc[DescValidBit] || (lvl == 3 && !desc[DescTableBit])) return res;
      if (lvl == 3 || !desc[DescTableBit]) begin
        low_bits       = (48'd1 << boundary) - 48'd1;
        res.phys_addr  = (desc[VaW-1:0] & ~low_bits) | (va & low_bits);
        res.fault      = 1'b0;
        res.leaf_level = 2'(lvl);
        return res;
      end
      page = desc[47:12];
    end
    return res;
  endfunction

  // Track configuration, predict on each request transfer, compare on each result transfer
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rsp_t expected;
    rsp_t observed;
    req_t item;
    if (!rst_ni) begin
      root_page_q = '0;
      rsp_due.delete();
      pending_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        root_page_q = cfg_wdata_i;
      end

      // check a result before queueing a new expectation
      if (rsp_mon.valid && rsp_mon.ready) begin
        observed = rsp_mon.payload;
        if (rsp_due.size() == 0) begin
          $error("result with nothing outstanding: phys_addr %h fault %b leaf_level %0d",
                 observed.phys_addr, observed.fault, observed.leaf_level);
          mismatch_count_o++;
        end else begin
          expected = rsp_due.pop_front();
          if (observed.phys_addr !== expected.phys_addr) begin
            $error("phys_addr: expected %h, got %h", expected.phys_addr, observed.phys_addr);
            mismatch_count_o++;
          end
          if (observed.fault !== expected.fault) begin
            $error("fault: expected %b, got %b", expected.fault, observed.fault);
            mismatch_count_o++;
          end
          if (observed.leaf_level !== expected.leaf_level) begin
            $error("leaf_level: expected %0d, got %0d", expected.leaf_level,
                   observed.leaf_level);
            mismatch_count_o++;
          end
        end
      end

      if (req_mon.valid && req_mon.ready) begin
        item = req_mon.payload;
        if (item.opcode == OpWrite) begin
          if (item.word_index < StoreWords) begin
            desc_shadow[item.word_index] = item.write_data;
          end
          rsp_due.push_back('0);
        end else begin
          rsp_due.push_back(predict_translation(item.virt_addr));
        end
      end

      pending_count_o = rsp_due.size();
    end
  end

endmodule

// ----- test/tb_page_table_walker_4k_unit.sv -----
`timescale 1ns / 1ps
module tb_page_table_walker_4k_unit;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [3:0] cfg_wdata_i = 4'd0;

  int mismatch_count;
  int pending_count;

  // Traffic shaping; stall_pct and hold_left are shared with the receiver process
  int         idle_pct   = 0;
  int         stall_pct  = 0;
  int         hold_left  = 0;
  int         sent_count = 0;
  logic [3:0] cur_root   = 4'd0;

  ptw4k_req_if req_bus ();
  ptw4k_rsp_if rsp_bus ();

  page_table_walker_4k_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  ptw4k_walk_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_mon          (req_bus),
    .rsp_mon          (rsp_bus),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // Table index drawn from the small set of entries defined at start-up
  function automatic logic [ptw4k_pkg::IdxW-1:0] pick_index();
    if ($urandom_range(7) == 0) return {ptw4k_pkg::IdxW{1'b1}};
    return ptw4k_pkg::IdxW'($urandom_range(6));
  endfunction

  function automatic logic [ptw4k_pkg::VaW-1:0] rand_va();
    logic [63:0] raw;
    raw = rand_word();
    return {pick_index(), pick_index(), pick_index(), pick_index(), raw[11:0]};
  endfunction

  function automatic logic [ptw4k_pkg::StoreAw-1:0] word_of(
      input logic [ptw4k_pkg::PageW-1:0] page,
      input logic [ptw4k_pkg::IdxW-1:0]  entry);
    return {page, entry};
  endfunction

  // Table descriptor with random junk in the ignored bits
  function automatic logic [ptw4k_pkg::DescW-1:0] table_entry(input logic [35:0] page);
    logic [63:0] raw;
    raw = rand_word();
    return {raw[63:48], page, raw[11:2], 2'b11};
  endfunction

  // Page number at or past the end of the store
  function automatic logic [35:0] beyond_page();
    logic [35:0] page;
    page = 36'(rand_word());
    if ($urandom_range(1) == 0) page = 36'(ptw4k_pkg::TablePages);
    else if (page < ptw4k_pkg::TablePages) page = page | 36'(ptw4k_pkg::TablePages);
    return page;
  endfunction

  function automatic logic [ptw4k_pkg::DescW-1:0] random_descriptor();
    logic [63:0] raw;
    int          pick;
    raw  = rand_word();
    pick = $urandom_range(99);
    if (pick < 30) return {raw[63:1], 1'b0};
    if (pick < 65) return table_entry(36'($urandom_range(ptw4k_pkg::TablePages - 1)));
    if (pick < 70) return table_entry(beyond_page());
    if (pick < 85) return {raw[63:2], 2'b01};
    return {raw[63:2], 2'b11};
  endfunction

  function automatic ptw4k_pkg::req_t write_item(
      input logic [ptw4k_pkg::StoreAw-1:0] word,
      input logic [ptw4k_pkg::DescW-1:0]   data);
    ptw4k_pkg::req_t item;
    item.opcode     = ptw4k_pkg::OpWrite;
    item.word_index = word;
    item.write_data = data;
    item.virt_addr  = ptw4k_pkg::VaW'(rand_word());
    return item;
  endfunction

  function automatic ptw4k_pkg::req_t translate_item(input logic [ptw4k_pkg::VaW-1:0] va);
    ptw4k_pkg::req_t item;
    item.opcode     = ptw4k_pkg::OpTranslate;
    item.word_index = ptw4k_pkg::StoreAw'($urandom());
    item.write_data = rand_word();
    item.virt_addr  = va;
    return item;
  endfunction

  // Offer one item, with a random gap ahead of it, and hold it until the transfer
  task automatic send(input ptw4k_pkg::req_t item);
    if ($urandom_range(99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    req_bus.valid   <= 1'b1;
    req_bus.payload <= item;
    do @(posedge clk_i); while (!req_bus.ready);
    @(negedge clk_i);
    sent_count++;
  endtask

  // Drop valid and wait for every owed result, then let the pipeline settle
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_root(input logic [3:0] root);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= root;
    cur_root     = root;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Build a walk path for a random address, then translate through it
  task automatic run_walk_sequence();
    logic [ptw4k_pkg::VaW-1:0]   va;
    logic [ptw4k_pkg::VaW-1:0]   low_bits;
    logic [35:0]                 next_page;
    logic [ptw4k_pkg::PageW-1:0] page;
    logic [ptw4k_pkg::IdxW-1:0]  entry;
    logic [ptw4k_pkg::DescW-1:0] raw;
    int                          depth;
    int                          flaw;
    int                          bad_lvl;
    int                          lvl;
    va    = rand_va();
    depth = $urandom_range(3);
    // flaws: invalid leaf, level 3 entry that is not a page, table pointer out of store
    flaw  = $urandom_range(9);
    if (flaw == 1) depth = 3;
    if (flaw == 2 && depth == 0) depth = 1;
    bad_lvl = (depth == 0) ? 0 : $urandom_range(depth - 1);
    page    = cur_root;
    for (lvl = 0; lvl <= depth; lvl++) begin
      entry = ptw4k_pkg::IdxW'(va >> (39 - 9 * lvl));
      if (lvl < depth) begin
        if (flaw == 2 && lvl == bad_lvl) begin
          send(write_item(word_of(page, entry), table_entry(beyond_page())));
          break;
        end
        next_page = 36'($urandom_range(ptw4k_pkg::TablePages - 1));
        send(write_item(word_of(page, entry), table_entry(next_page)));
        page = ptw4k_pkg::PageW'(next_page);
      end else begin
        raw = rand_word();
        if (flaw == 0) raw[0] = 1'b0;
        else if (flaw == 1 || depth < 3) raw[1:0] = 2'b01;
        else raw[1:0] = 2'b11;
        send(write_item(word_of(page, entry), raw));
      end
    end
    send(translate_item(va));
    // same path, fresh offset below the leaf boundary
    if ($urandom_range(1) == 0) begin
      low_bits = (48'd1 << (39 - 9 * depth)) - 48'd1;
      send(translate_item((va & ~low_bits) | (ptw4k_pkg::VaW'(rand_word()) & low_bits)));
    end
  endtask

  task automatic run_phase(input logic [3:0] root, input int send_idle, input int rsp_stall,
                           input int items, input int hold);
    set_root(root);
    idle_pct   = send_idle;
    stall_pct  = rsp_stall;
    hold_left  = hold;
    sent_count = 0;
    while (sent_count < items) begin
      if ($urandom_range(3) != 0) run_walk_sequence();
      else if ($urandom_range(1) == 0)
        send(write_item(ptw4k_pkg::StoreAw'($urandom()), random_descriptor()));
      else send(translate_item(rand_va()));
    end
    drain();
  endtask

  // Result side: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : stimulus
    int                         p;
    int                         e;
    logic [ptw4k_pkg::IdxW-1:0] entry_idx;
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Define every entry that a random walk can reach before any walk runs
    set_root(4'd0);
    for (p = 0; p < ptw4k_pkg::TablePages; p++) begin
      for (e = 0; e < 8; e++) begin
        entry_idx = (e == 7) ? {ptw4k_pkg::IdxW{1'b1}} : ptw4k_pkg::IdxW'(e);
        send(write_item(word_of(ptw4k_pkg::PageW'(p), entry_idx), random_descriptor()));
      end
    end

    // Directed: leaves at every level, each fault kind, field extremes
    send(write_item(word_of(4'd0, 9'd0), {16'hFFFF, 36'd1, 10'h3FF, 2'b11}));
    send(write_item(word_of(4'd1, 9'd0), 64'hFFFF_FFFF_FFFF_FFFD));
    send(translate_item(48'h0));
    send(translate_item(48'h0000_3FFF_FFFF));
    send(write_item(word_of(4'd0, 9'd511), 64'h0000_8000_0000_0001));
    send(translate_item(48'hFFFF_FFFF_FFFF));
    send(write_item(word_of(4'd0, 9'd1), table_entry(36'd2)));
    send(write_item(word_of(4'd2, 9'd2), table_entry(36'd3)));
    send(write_item(word_of(4'd3, 9'd3), table_entry(36'd4)));
    send(write_item(word_of(4'd4, 9'd4), {16'h0, 36'hF_FFFF_FFFF, 10'h0, 2'b11}));
    send(translate_item({9'd1, 9'd2, 9'd3, 9'd4, 12'hABC}));
    send(write_item(word_of(4'd3, 9'd5), 64'h0000_FFFF_FFFF_FFFD));
    send(translate_item({9'd1, 9'd2, 9'd5, 9'd0, 12'h000}));
    send(write_item(word_of(4'd4, 9'd6), 64'h1));
    send(translate_item({9'd1, 9'd2, 9'd3, 9'd6, 12'hFFF}));
    send(write_item(word_of(4'd4, 9'd7), 64'h0));
    send(translate_item({9'd1, 9'd2, 9'd3, 9'd7, 12'h123}));
    send(write_item(word_of(4'd2, 9'd8), table_entry(36'hF_FFFF_FFFF)));
    send(translate_item({9'd1, 9'd8, 9'd0, 9'd0, 12'h000}));
    send(write_item(word_of(4'd2, 9'd9), table_entry(36'(ptw4k_pkg::TablePages))));
    send(translate_item({9'd1, 9'd9, 9'd0, 9'd0, 12'h000}));
    send(write_item(word_of(4'd15, 9'd511), 64'hFFFF_FFFF_FFFF_FFFF));
    drain();

    // Random phases across root settings and traffic shapes
    run_phase(4'd15, 0, 0, 150, 0);
    run_phase(4'($urandom_range(15)), 56, 0, 150, 0);
    run_phase(4'($urandom_range(15)), 0, 56, 150, 0);
    run_phase(4'd0, 18, 18, 150, 0);
    // long result hold-off while items keep coming, so the input backs up
    run_phase(4'($urandom_range(15)), 0, 0, 100, 400);

    if (mismatch_count == 0) begin
      $display("** page_table_walker_4k_unit: PASSED **");
    end else begin
      $display("** page_table_walker_4k_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(5_000_000);
    $display("** page_table_walker_4k_unit: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/ptw4k_pkg.sv
rtl/core/ptw4k_req_if.sv
rtl/core/ptw4k_rsp_if.sv
rtl/core/ptw4k_ram.sv
rtl/core/ptw4k_walker.sv
rtl/core/page_table_walker_4k_unit.sv
test/ptw4k_walk_checker.sv
test/tb_page_table_walker_4k_unit.sv
